[sv/utf8_encoding_detector_defines.svh]
// Assertion macros shared by the detector modules.
`ifndef UTF8_ENCODING_DETECTOR_DEFINES_SVH
`define UTF8_ENCODING_DETECTOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define UED_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define UED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/utf8ed_pkg.sv]
// Types, constants and helper functions of the UTF-8 encoding detector.
`timescale 1ns / 1ps
package utf8ed_pkg;

  typedef logic [7:0] byte_t;

  localparam int WIN_DEPTH = 6;

  // Byte order mark.
  localparam byte_t BOM_BYTE0 = 8'hEF;
  localparam byte_t BOM_BYTE1 = 8'hBB;
  localparam byte_t BOM_BYTE2 = 8'hBF;

  // Lead byte tags after shifting out the payload bits.
  localparam logic [2:0] LEAD2_TAG = 3'h6;
  localparam logic [3:0] LEAD3_TAG = 4'hE;
  localparam logic [4:0] LEAD4_TAG = 5'h1E;
  localparam logic [5:0] LEAD5_TAG = 6'h3E;
  localparam logic [6:0] LEAD6_TAG = 7'h7E;
  localparam logic [1:0] CONT_TAG  = 2'h2;

  // Ratio test: 100 * valid >= 91 * total, i.e. at least 91 percent valid.
  localparam int PCT_SCALE  = 100;
  localparam int PCT_THRESH = 91;

  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_BOM     = 2'd0;
  localparam verdict_t VERDICT_ASCII   = 2'd1;
  localparam verdict_t VERDICT_NOBOM   = 2'd2;
  localparam verdict_t VERDICT_INVALID = 2'd3;

  typedef struct packed {
    logic load_byte;   // a word is accepted this cycle
    logic drain_step;  // decide the window head once
    logic calc_prod;   // register the ratio products
    logic load_out;    // capture the result and clear the string state
  } dp_cmd_t;

  typedef struct packed {
    logic fill_zero;
  } dp_stat_t;

  // Length of the form a lead byte announces: 1 ascii, 2..6 lead, 0 other.
  function automatic logic [2:0] lead_len(input byte_t c);
    logic [2:0] len;
    len = 3'd0;
    if (c[7] == 1'b0)                len = 3'd1;
    else if (c[7:5] == LEAD2_TAG)    len = 3'd2;
    else if (c[7:4] == LEAD3_TAG)    len = 3'd3;
    else if (c[7:3] == LEAD4_TAG)    len = 3'd4;
    else if (c[7:2] == LEAD5_TAG)    len = 3'd5;
    else if (c[7:1] == LEAD6_TAG)    len = 3'd6;
    return len;
  endfunction

  function automatic logic is_cont(input byte_t c);
    return c[7:6] == CONT_TAG;
  endfunction

  function automatic byte_t bom_byte(input logic [1:0] idx);
    byte_t b;
    unique case (idx)
      2'd0:    b = BOM_BYTE0;
      2'd1:    b = BOM_BYTE1;
      default: b = BOM_BYTE2;
    endcase
    return b;
  endfunction

endpackage

[sv/utf8ed_in_if.sv]
// Input channel: one string byte per word with its last flag.
`timescale 1ns / 1ps
interface utf8ed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[sv/utf8ed_out_if.sv]
// Output channel: verdict and counts for one string.
`timescale 1ns / 1ps
interface utf8ed_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [23:0] valid_count;
  logic [23:0] invalid_count;

  modport source (output valid, output verdict, output valid_count,
                  output invalid_count, input ready);
  modport sink (input valid, input verdict, input valid_count,
                input invalid_count, output ready);
endinterface

[sv/utf8ed_dp.sv]
// Datapath: lookahead window, BOM tracking, tallies, ratio test and result register.
`timescale 1ns / 1ps
`include "utf8_encoding_detector_defines.svh"
module utf8ed_dp #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  utf8ed_pkg::dp_cmd_t cmd,
  output utf8ed_pkg::dp_stat_t stat,
  input  utf8ed_pkg::byte_t   data_byte,
  output logic [1:0]          verdict,
  output logic [23:0]         valid_count,
  output logic [23:0]         invalid_count
);
  import utf8ed_pkg::*;

  localparam int PW = COUNT_WIDTH + 8;

  byte_t                  win [WIN_DEPTH];
  logic [2:0]             fill;
  logic                   ended;
  logic [1:0]             bom_prog;
  logic                   bom_ok;
  logic [COUNT_WIDTH-1:0] vtally;
  logic [COUNT_WIDTH-1:0] itally;
  logic [PW-1:0]          prod_v;
  logic [PW-1:0]          prod_t;

  byte_t                  win_ins [WIN_DEPTH];
  byte_t                  src [WIN_DEPTH];
  byte_t                  win_sh [WIN_DEPTH];
  logic [2:0]             dec_len;
  logic                   dec_ok;
  logic [2:0]             dec_n;
  logic                   dec_valid;
  logic                   dec_invalid;
  logic                   take;
  logic                   full_dec;
  logic                   do_dec;
  logic [COUNT_WIDTH:0]   total;
  logic [COUNT_WIDTH+23:0] v_ext;
  logic [COUNT_WIDTH+23:0] i_ext;

  assign take     = cmd.load_byte && !ended && (data_byte != 8'd0);
  assign full_dec = take && (fill == 3'(WIN_DEPTH - 1));
  assign do_dec   = full_dec || cmd.drain_step;

  // Window with the incoming byte written at the fill position.
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_ins[i] = (fill == 3'(i)) ? data_byte : win[i];
      src[i]     = cmd.drain_step ? win[i] : win_ins[i];
    end
  end

  // Decide the head byte; positions past the fill hold zeros, which are
  // never continuation bytes, so a valid form never reaches past the fill.
  always_comb begin
    dec_len = lead_len(src[0]);
    dec_ok  = (dec_len >= 3'd2);
    for (int k = 1; k < WIN_DEPTH; k++) begin
      if ((3'(k) < dec_len) && !is_cont(src[k])) dec_ok = 1'b0;
    end
    dec_valid   = 1'b0;
    dec_invalid = 1'b0;
    dec_n       = 3'd1;
    if (dec_len == 3'd1) begin
      dec_n = 3'd1;
    end else if (dec_ok) begin
      dec_n     = dec_len;
      dec_valid = 1'b1;
    end else begin
      dec_invalid = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_sh[i] = '0;
      for (int j = 1; j < WIN_DEPTH; j++) begin
        if (j == i + int'(dec_n)) win_sh[i] = src[j];
      end
    end
  end

  assign total = {1'b0, vtally} + {1'b0, itally};
  assign v_ext = (COUNT_WIDTH + 24)'(vtally);
  assign i_ext = (COUNT_WIDTH + 24)'(itally);

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      for (int i = 0; i < WIN_DEPTH; i++) win[i] <= '0;
      fill     <= '0;
      ended    <= 1'b0;
      bom_prog <= '0;
      bom_ok   <= 1'b1;
      vtally   <= '0;
      itally   <= '0;
    end else begin
      if (cmd.load_byte && !ended) begin
        if (bom_ok && (bom_prog != 2'd3)) begin
          if (data_byte == bom_byte(bom_prog)) bom_prog <= bom_prog + 2'd1;
          else bom_ok <= 1'b0;
        end
        if (data_byte == 8'd0) ended <= 1'b1;
      end
      if (do_dec) begin
        for (int i = 0; i < WIN_DEPTH; i++) win[i] <= win_sh[i];
        if (full_dec) fill <= 3'(WIN_DEPTH) - dec_n;
        else fill <= fill - dec_n;
        if (dec_valid && (vtally != '1)) vtally <= vtally + 1'b1;
        if (dec_invalid && (itally != '1)) itally <= itally + 1'b1;
      end else if (take) begin
        for (int i = 0; i < WIN_DEPTH; i++) win[i] <= win_ins[i];
        fill <= fill + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_prod) begin
      prod_v <= PW'(vtally) * PW'(PCT_SCALE);
      prod_t <= PW'(total) * PW'(PCT_THRESH);
    end
    if (cmd.load_out) begin
      if (bom_ok && (bom_prog == 2'd3)) begin
        verdict       <= VERDICT_BOM;
        valid_count   <= '0;
        invalid_count <= '0;
      end else begin
        if (total == '0) verdict <= VERDICT_ASCII;
        else if (prod_v >= prod_t) verdict <= VERDICT_NOBOM;
        else verdict <= VERDICT_INVALID;
        valid_count   <= v_ext[23:0];
        invalid_count <= i_ext[23:0];
      end
    end
  end

  assign stat.fill_zero = (fill == 3'd0);

  `UED_ASSERT_ALWAYS(a_fill_bound, fill < 3'(WIN_DEPTH), "window fill reached the window depth")
  `UED_ASSERT_IMP(a_drain_nonempty, cmd.drain_step, fill != 3'd0, "drain step on an empty window")
  `UED_ASSERT_NEXT(a_clear_after_out, cmd.load_out, (fill == 3'd0) && (vtally == '0) && (itally == '0) && bom_ok && !ended, "string state not cleared after result")
endmodule

[sv/utf8ed_ctrl.sv]
// Controller: scan, drain, ratio test and result handoff sequencing.
`timescale 1ns / 1ps
`include "utf8_encoding_detector_defines.svh"
module utf8ed_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8ed_pkg::dp_cmd_t  cmd,
  input  utf8ed_pkg::dp_stat_t stat
);
  import utf8ed_pkg::*;

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_PROD  = 2'd2;
  localparam logic [1:0] S_CMP   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       in_acc;

  assign in_ready = (state == S_RUN);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_RUN: begin
        cmd.load_byte = in_acc;
        if (in_acc && in_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.fill_zero) state_next = S_PROD;
        else cmd.drain_step = 1'b1;
      end
      S_PROD: begin
        cmd.calc_prod = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        // Wait here until the result register is free.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  assign out_valid_next = cmd.load_out || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `UED_ASSERT_NEXT(a_last_drains, in_acc && in_last, state == S_DRAIN, "last word did not start the drain")
  `UED_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid || out_ready, "pending result overwritten")
  `UED_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid && (state == S_RUN), "loaded result not presented")
endmodule

[sv/utf8_encoding_detector.sv]
// Top level of the UTF-8 encoding detector.
//
//   channel   dir   words                              handshake
//   in_ch     in    data_byte[7:0], last_byte          valid/ready
//   out_ch    out   verdict[1:0], valid_count[23:0],   valid/ready
//                   invalid_count[23:0]
//
// A string word is taken every cycle while scanning; a full window decides one
// head position in the same cycle. After the last word, the window drains one
// head form per cycle (at most five positions are held); then the ratio products
// are registered, and the compare loads the result register once it is free.
// Input ready is low from the last word until the result is loaded; a stalled
// result holds in the output register while the next string is scanned.
// Reset is synchronous and returns all string state to empty.
`timescale 1ns / 1ps
module utf8_encoding_detector #(
  parameter int COUNT_WIDTH = 24
) (
  input logic         clk,
  input logic         rst,
  utf8ed_in_if.sink   in_ch,
  utf8ed_out_if.source out_ch
);
  import utf8ed_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  utf8ed_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_byte),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  utf8ed_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .data_byte     (in_ch.data_byte),
    .verdict       (out_ch.verdict),
    .valid_count   (out_ch.valid_count),
    .invalid_count (out_ch.invalid_count)
  );
endmodule
